[hdl/dijkstra_relaxation_engine_defines.svh]
// ----------------------------------------------------------------------------
// dijkstra relaxation engine assertion macros
// implication checks used by the engine modules
// ----------------------------------------------------------------------------
`ifndef DIJKSTRA_RELAXATION_ENGINE_DEFINES_SVH
`define DIJKSTRA_RELAXATION_ENGINE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DRE_ASSERT_IMPL(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("same-cycle check failed");
`define DRE_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define DRE_ASSERT_IMPL(lbl, clk, rst_n, a, b)
`define DRE_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

[hdl/dre_pkg.sv]
// ----------------------------------------------------------------------------
// dre_pkg
// shared types and constants of the shortest-path engine
// ----------------------------------------------------------------------------
package dre_pkg;

  localparam int VERTEX_COUNT_DEF = 1024;
  localparam int ARC_COUNT_DEF    = 4096;
  localparam int LOG_DEPTH_DEF    = 50;

  localparam int IDX_W    = 14;
  localparam int WEIGHT_W = 20;

  localparam logic [30:0] COST_MAX  = 31'h7FFF_FFFF;
  localparam logic [7:0]  END_BIT   = 8'h10;
  localparam logic [7:0]  DREQ_BIT  = 8'h04;
  localparam logic [7:0]  NOT_DRAIN = 8'hF7;

  localparam int CB_RESET = 0;
  localparam int CB_RELAX = 1;
  localparam int CB_DREQ  = 2;
  localparam int CB_DRAIN = 3;
  localparam int CB_END   = 4;

  typedef enum logic [2:0] {
    CMD_VERTEX_WR = 3'd0,
    CMD_ARC_END_WR = 3'd1,
    CMD_ARC_WT_WR = 3'd2,
    CMD_CTRL_WR = 3'd3,
    CMD_CTRL_RD = 3'd4,
    CMD_VERTEX_RD = 3'd5,
    CMD_STEP = 3'd6
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_VREAD,
    ST_DRAIN_RD,
    ST_DRAIN_OUT,
    ST_SCAN,
    ST_DECIDE,
    ST_ARC_RD,
    ST_ARC_CHK,
    ST_HEAD,
    ST_MARK
  } state_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic vread_out;
    logic drain_rd;
    logic drain_out;
    logic scan;
    logic decide;
    logic arc_rd;
    logic arc_chk;
    logic head_chk;
    logic mark;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic ctl_reset;
    logic ctl_drain;
    logic relax_go;
    logic scan_done;
    logic run_done;
    logic arc_end;
    logic arc_head;
    logic arc_stop;
    logic abort;
    logic drain_last;
  } dp_stat_t;

endpackage

[hdl/dre_ram.sv]
// ----------------------------------------------------------------------------
// dre_ram
// single write port, single registered read port memory
// ----------------------------------------------------------------------------
module dre_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/dre_ctrl.sv]
// ----------------------------------------------------------------------------
// dre_ctrl
// sequencer for request decode, vertex scan, arc walk and log drain
// ----------------------------------------------------------------------------
module dre_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  dre_pkg::dp_stat_t stat,
  output dre_pkg::dp_cmd_t  cmd
);

  dre_pkg::state_t state_r;
  dre_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dre_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      dre_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = dre_pkg::ST_EXEC;
        end
      end
      dre_pkg::ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = dre_pkg::ST_IDLE;
        case (dre_pkg::cmd_t'(stat.cmd))
          dre_pkg::CMD_VERTEX_RD: state_nxt = dre_pkg::ST_VREAD;
          dre_pkg::CMD_STEP: begin
            if (stat.ctl_reset) begin
              state_nxt = dre_pkg::ST_IDLE;
            end else if (stat.ctl_drain) begin
              state_nxt = dre_pkg::ST_DRAIN_RD;
            end else if (stat.relax_go) begin
              state_nxt = dre_pkg::ST_SCAN;
            end
          end
          default: state_nxt = dre_pkg::ST_IDLE;
        endcase
      end
      dre_pkg::ST_VREAD: begin
        cmd.vread_out = 1'b1;
        state_nxt     = dre_pkg::ST_IDLE;
      end
      dre_pkg::ST_DRAIN_RD: begin
        cmd.drain_rd = 1'b1;
        state_nxt    = dre_pkg::ST_DRAIN_OUT;
      end
      dre_pkg::ST_DRAIN_OUT: begin
        cmd.drain_out = 1'b1;
        state_nxt = stat.drain_last ? dre_pkg::ST_IDLE : dre_pkg::ST_DRAIN_RD;
      end
      dre_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = dre_pkg::ST_DECIDE;
        end
      end
      dre_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = stat.run_done ? dre_pkg::ST_IDLE : dre_pkg::ST_ARC_RD;
      end
      dre_pkg::ST_ARC_RD: begin
        cmd.arc_rd = 1'b1;
        state_nxt  = stat.arc_end ? dre_pkg::ST_MARK : dre_pkg::ST_ARC_CHK;
      end
      dre_pkg::ST_ARC_CHK: begin
        cmd.arc_chk = 1'b1;
        if (stat.arc_head) begin
          state_nxt = dre_pkg::ST_HEAD;
        end else if (stat.arc_stop) begin
          state_nxt = dre_pkg::ST_MARK;
        end else begin
          state_nxt = dre_pkg::ST_ARC_RD;
        end
      end
      dre_pkg::ST_HEAD: begin
        cmd.head_chk = 1'b1;
        state_nxt    = stat.abort ? dre_pkg::ST_IDLE : dre_pkg::ST_ARC_RD;
      end
      dre_pkg::ST_MARK: begin
        cmd.mark  = 1'b1;
        state_nxt = dre_pkg::ST_IDLE;
      end
      default: state_nxt = dre_pkg::ST_IDLE;
    endcase
  end

endmodule

[hdl/dre_dpath.sv]
// ----------------------------------------------------------------------------
// dre_dpath
// tables, control register, relax log and scan/relax arithmetic
// ----------------------------------------------------------------------------
`include "dijkstra_relaxation_engine_defines.svh"

module dre_dpath #(
  parameter int VERTEX_COUNT = dre_pkg::VERTEX_COUNT_DEF,
  parameter int ARC_COUNT    = dre_pkg::ARC_COUNT_DEF,
  parameter int LOG_DEPTH    = dre_pkg::LOG_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [2:0]        in_command,
  input  logic [13:0]       in_address,
  input  logic [31:0]       in_data,
  input  logic              cfg_we,
  input  logic [30:0]       cfg_data,
  input  dre_pkg::dp_cmd_t  cmd,
  output dre_pkg::dp_stat_t stat,
  output logic              out_valid,
  output logic [31:0]       out_read_data,
  output logic              out_last,
  output logic              out_interrupt
);

  localparam int VAW = $clog2(VERTEX_COUNT);
  localparam int VCW = $clog2(VERTEX_COUNT + 1);
  localparam int AAW = (ARC_COUNT > 1) ? $clog2(ARC_COUNT) : 1;
  localparam int ACW = $clog2(ARC_COUNT + 1);
  localparam int LAW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int FW  = $clog2(LOG_DEPTH + 1);
  localparam logic [14:0]    VC15    = 15'(VERTEX_COUNT);
  localparam logic [14:0]    AC15    = 15'(ARC_COUNT);
  localparam logic [VCW-1:0] VC_CNT  = VCW'(VERTEX_COUNT);
  localparam logic [ACW-1:0] AC_CNT  = ACW'(ARC_COUNT);
  localparam logic [FW-1:0]  LD_CNT  = FW'(LOG_DEPTH);
  localparam logic [FW-1:0]  LD_M1   = FW'(LOG_DEPTH - 1);
  localparam logic [LAW-1:0] DK_LAST = LAW'(LOG_DEPTH - 1);

  // request latch
  logic [2:0]  cmd_r;
  logic [13:0] addr_r;
  logic [31:0] data_r;

  logic [7:0]  ctrl_r;
  logic        irq_r;
  logic [FW-1:0] fill_r;
  logic [30:0] inf_r;

  // scan and relax state
  logic [VCW-1:0] idx_r;
  logic [VAW-1:0] pidx_r;
  logic           pend_r;
  logic [30:0]    min_r;
  logic [13:0]    best_r;
  logic           anyu_r;
  logic           alli_r;
  logic [ACW-1:0] arc_r;
  logic           found_r;
  logic [13:0]    head_r;
  logic [30:0]    sum_r;
  logic [LAW-1:0] dk_r;

  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        out_last_r;
  logic        out_irq_r;

  // memory ports
  logic           v_we;
  logic [VAW-1:0] v_waddr;
  logic [31:0]    v_wdata;
  logic [VAW-1:0] v_raddr;
  logic [31:0]    v_rdata;
  logic           ae_we;
  logic           aw_we;
  logic [31:0]    ae_rdata;
  logic [dre_pkg::WEIGHT_W-1:0] aw_rdata;
  logic           log_we;
  logic [31:0]    log_rdata;

  logic        v_addr_ok;
  logic        a_addr_ok;
  logic        ctrl_rd;
  logic        scan_issue;
  logic        match;
  logic [13:0] head_q;
  logic        head_ok;
  logic [31:0] sum_full;
  logic        relax_due;
  logic        fill_full;
  logic        fill_last;
  logic        drain_last;
  logic [7:0]  ctrl_dreq;
  logic [7:0]  ctrl_end;

  assign v_addr_ok  = {1'b0, addr_r} < VC15;
  assign a_addr_ok  = {1'b0, addr_r} < AC15;
  assign ctrl_rd    = cmd.exec && cmd_r == dre_pkg::CMD_CTRL_RD;
  assign scan_issue = cmd.scan && (idx_r != VC_CNT);
  assign match      = ae_rdata[13:0] == best_r;
  assign head_q     = ae_rdata[31:18];
  assign head_ok    = {1'b0, head_q} < VC15;
  assign sum_full   = {1'b0, min_r} + 32'(aw_rdata);
  assign relax_due  = !v_rdata[31] && (v_rdata[30:0] > sum_r);
  assign fill_full  = fill_r == LD_CNT;
  assign fill_last  = fill_r == LD_M1;
  assign drain_last = dk_r == DK_LAST;
  assign ctrl_dreq  = (ctrl_r | dre_pkg::DREQ_BIT) & dre_pkg::NOT_DRAIN;
  // end of run: set end bit, ask for a drain when the log holds entries
  assign ctrl_end   = (fill_r != '0)
                    ? ((ctrl_r | dre_pkg::END_BIT | dre_pkg::DREQ_BIT) & dre_pkg::NOT_DRAIN)
                    : (ctrl_r | dre_pkg::END_BIT);

  always_comb begin
    v_we    = 1'b0;
    v_waddr = addr_r[VAW-1:0];
    v_wdata = data_r;
    v_raddr = addr_r[VAW-1:0];
    if (cmd.exec && cmd_r == dre_pkg::CMD_VERTEX_WR && v_addr_ok) begin
      v_we = 1'b1;
    end
    if (cmd.scan) begin
      v_raddr = idx_r[VAW-1:0];
    end
    if (cmd.arc_chk) begin
      v_raddr = head_q[VAW-1:0];
    end
    if (cmd.head_chk && relax_due && !fill_full) begin
      v_we    = 1'b1;
      v_waddr = head_r[VAW-1:0];
      v_wdata = {1'b0, sum_r};
    end
    if (cmd.mark) begin
      v_we    = 1'b1;
      v_waddr = best_r[VAW-1:0];
      v_wdata = {1'b1, min_r};
    end
  end

  assign ae_we  = cmd.exec && cmd_r == dre_pkg::CMD_ARC_END_WR && a_addr_ok;
  assign aw_we  = cmd.exec && cmd_r == dre_pkg::CMD_ARC_WT_WR && a_addr_ok;
  assign log_we = cmd.head_chk && relax_due && !fill_full;

  dre_ram #(.WIDTH(32), .DEPTH(VERTEX_COUNT)) u_vertex_ram (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rdata)
  );

  dre_ram #(.WIDTH(32), .DEPTH(ARC_COUNT)) u_arc_end_ram (
    .clk(clk), .we(ae_we), .waddr(addr_r[AAW-1:0]), .wdata(data_r),
    .raddr(arc_r[AAW-1:0]), .rdata(ae_rdata)
  );

  dre_ram #(.WIDTH(dre_pkg::WEIGHT_W), .DEPTH(ARC_COUNT)) u_arc_wt_ram (
    .clk(clk), .we(aw_we), .waddr(addr_r[AAW-1:0]),
    .wdata(data_r[dre_pkg::WEIGHT_W-1:0]),
    .raddr(arc_r[AAW-1:0]), .rdata(aw_rdata)
  );

  dre_ram #(.WIDTH(32), .DEPTH(LOG_DEPTH)) u_log_ram (
    .clk(clk), .we(log_we), .waddr(fill_r[LAW-1:0]),
    .wdata({best_r, 4'b0000, head_r}),
    .raddr(dk_r), .rdata(log_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r  <= in_command;
      addr_r <= in_address;
      data_r <= in_data;
    end
    if (cmd.exec) begin
      idx_r  <= '0;
      pend_r <= 1'b0;
      min_r  <= inf_r;
      best_r <= '0;
      anyu_r <= 1'b0;
      alli_r <= 1'b1;
      dk_r   <= '0;
    end
    if (cmd.scan) begin
      pend_r <= scan_issue;
      pidx_r <= idx_r[VAW-1:0];
      if (scan_issue) begin
        idx_r <= idx_r + 1'b1;
      end
      if (pend_r && !v_rdata[31]) begin
        anyu_r <= 1'b1;
        if (min_r > v_rdata[30:0]) begin
          min_r  <= v_rdata[30:0];
          best_r <= 14'(pidx_r);
        end
        if (v_rdata[30:0] < inf_r) begin
          alli_r <= 1'b0;
        end
      end
    end
    if (cmd.decide) begin
      arc_r   <= '0;
      found_r <= 1'b0;
    end
    if (cmd.arc_chk) begin
      head_r <= head_q;
      sum_r  <= sum_full[31] ? dre_pkg::COST_MAX : sum_full[30:0];
      if (match) begin
        found_r <= 1'b1;
      end
      if ((match && !head_ok) || (!match && !found_r)) begin
        arc_r <= arc_r + 1'b1;
      end
    end
    if (cmd.head_chk && !(relax_due && (fill_full || fill_last))) begin
      arc_r <= arc_r + 1'b1;
    end
    if (cmd.drain_out && !drain_last) begin
      dk_r <= dk_r + 1'b1;
    end
    if (cmd.exec) begin
      out_data_r <= {24'b0, ctrl_r};
    end else if (cmd.vread_out) begin
      out_data_r <= v_addr_ok ? v_rdata : 32'b0;
    end else if (cmd.drain_out) begin
      out_data_r <= (8'(dk_r) < 8'(fill_r)) ? log_rdata : 32'b0;
    end else begin
      out_data_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r      <= '0;
      irq_r       <= 1'b0;
      fill_r      <= '0;
      inf_r       <= dre_pkg::COST_MAX;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      out_irq_r   <= 1'b0;
    end else begin
      out_valid_r <= ctrl_rd || cmd.vread_out || cmd.drain_out;
      out_last_r  <= ctrl_rd || cmd.vread_out || (cmd.drain_out && drain_last);
      out_irq_r   <= cmd.drain_out ? 1'b0 : irq_r;
      if (cfg_we) begin
        inf_r <= cfg_data;
      end
      if (cmd.exec) begin
        case (dre_pkg::cmd_t'(cmd_r))
          dre_pkg::CMD_CTRL_WR: ctrl_r <= data_r[7:0];
          dre_pkg::CMD_STEP: begin
            if (ctrl_r[dre_pkg::CB_RESET]) begin
              ctrl_r <= '0;
              irq_r  <= 1'b0;
              fill_r <= '0;
            end else if (ctrl_r[dre_pkg::CB_DRAIN]) begin
              irq_r <= 1'b0;
            end else if (ctrl_r[dre_pkg::CB_RELAX] && !ctrl_r[dre_pkg::CB_DREQ]) begin
              irq_r <= 1'b0;
            end else begin
              irq_r <= ctrl_r[dre_pkg::CB_END];
            end
          end
          default: ;
        endcase
      end
      if (cmd.drain_out && drain_last) begin
        fill_r <= '0;
        ctrl_r <= ctrl_r & dre_pkg::NOT_DRAIN;
      end
      if (cmd.decide && (!anyu_r || alli_r)) begin
        ctrl_r <= ctrl_end;
        irq_r  <= 1'b1;
      end
      if (cmd.head_chk && relax_due) begin
        if (!fill_full) begin
          fill_r <= fill_r + 1'b1;
        end
        // log full: stop here, leave the vertex unvisited
        if (fill_full || fill_last) begin
          ctrl_r <= ctrl_dreq;
          irq_r  <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    stat            = '0;
    stat.cmd        = cmd_r;
    stat.ctl_reset  = ctrl_r[dre_pkg::CB_RESET];
    stat.ctl_drain  = ctrl_r[dre_pkg::CB_DRAIN];
    stat.relax_go   = ctrl_r[dre_pkg::CB_RELAX] && !ctrl_r[dre_pkg::CB_DREQ];
    stat.scan_done  = (idx_r == VC_CNT) && !pend_r;
    stat.run_done   = !anyu_r || alli_r;
    stat.arc_end    = arc_r == AC_CNT;
    stat.arc_head   = match && head_ok;
    stat.arc_stop   = !match && found_r;
    stat.abort      = relax_due && (fill_full || fill_last);
    stat.drain_last = drain_last;
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_last      = out_last_r;
  assign out_interrupt = out_irq_r;

  `DRE_ASSERT_IMPL(a_fill_bound, clk, rst_n, 1'b1, fill_r <= LD_CNT)
  `DRE_ASSERT_IMPL(a_last_valid, clk, rst_n, out_last_r, out_valid_r)
  `DRE_ASSERT_IMPL(a_log_room, clk, rst_n, log_we, fill_r != LD_CNT)
  `DRE_ASSERT_NEXT(a_drain_clears, clk, rst_n, cmd.drain_out && drain_last, fill_r == '0)

endmodule

[hdl/dijkstra_relaxation_engine.sv]
// ----------------------------------------------------------------------------
// dijkstra_relaxation_engine
// shortest-path engine: vertex/arc tables, control register, relax log
// ----------------------------------------------------------------------------
// channel  | handshake               | payload
// in_      | start & !busy           | in_command, in_address, in_data
// out_     | out_valid, one cycle    | out_read_data, out_last, out_interrupt
// cfg_     | cfg_valid & cfg_ready   | cfg_data (infinite cost)
//
// writes and control requests are decoded after the accept cycle, vertex reads
// are also read out; a result shows in the cycle after the last busy cycle
// a step: decode, vertex scan, decide, then a read and a check per arc, a head
// check for a run arc with head in range (one vertex ram port), mark visited
// a drain: decode, then a read and an output per log slot, LOG_DEPTH results
// busy stays high for the whole request; results cannot be held off
// reset is synchronous; tables hold no reset value
// ----------------------------------------------------------------------------
module dijkstra_relaxation_engine #(
  parameter int VERTEX_COUNT = dre_pkg::VERTEX_COUNT_DEF,
  parameter int ARC_COUNT    = dre_pkg::ARC_COUNT_DEF,
  parameter int LOG_DEPTH    = dre_pkg::LOG_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_command,
  input  logic [13:0] in_address,
  input  logic [31:0] in_data,
  output logic        out_valid,
  output logic [31:0] out_read_data,
  output logic        out_last,
  output logic        out_interrupt,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_data
);

  dre_pkg::dp_cmd_t  cmd;
  dre_pkg::dp_stat_t stat;

  assign cfg_ready = !busy;

  dre_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .stat(stat), .cmd(cmd)
  );

  dre_dpath #(
    .VERTEX_COUNT(VERTEX_COUNT), .ARC_COUNT(ARC_COUNT), .LOG_DEPTH(LOG_DEPTH)
  ) u_dpath (
    .clk(clk), .rst_n(rst_n),
    .in_command(in_command), .in_address(in_address), .in_data(in_data),
    .cfg_we(cfg_valid && cfg_ready), .cfg_data(cfg_data),
    .cmd(cmd), .stat(stat),
    .out_valid(out_valid), .out_read_data(out_read_data),
    .out_last(out_last), .out_interrupt(out_interrupt)
  );

endmodule
